### src/timeout_interval_timer_table_top_defines.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Shared concurrent assertion forms used by the timer table checker.
// ----------------------------------------------------------------------------
`ifndef TIMEOUT_INTERVAL_TIMER_TABLE_TOP_DEFINES_SVH
`define TIMEOUT_INTERVAL_TIMER_TABLE_TOP_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define TITT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TITT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/titt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, request and result codes, and the word types of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package titt_pkg;

  localparam int SLOTS   = 16;
  localparam int MAX_OUT = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET_ONCE = 2'd1,
    REQ_SET_REC  = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_SET_OK   = 2'd0,
    KIND_SET_FULL = 2'd1,
    KIND_CLEARED  = 2'd2,
    KIND_EXPIRED  = 2'd3
  } res_kind_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] delay_ticks;
    logic [31:0] timer_id;
  } req_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [31:0] result_id;
    logic        was_recurring;
    logic        last;
  } res_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_flags_t;

endpackage

### src/titt_cmp.sv
// ----------------------------------------------------------------------------
// Timer table compare unit
// Subtracts b from a modulo 2^32 and compares the difference against c.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module titt_cmp (
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  input  logic [31:0]          c_i,
  output titt_pkg::cmp_flags_t flags_o
);
  import titt_pkg::*;

  logic [31:0] diff;

  assign diff       = a_i - b_i;
  assign flags_o.eq = (diff == c_i);
  assign flags_o.lt = (diff < c_i);

endmodule

### src/timeout_interval_timer_table_top.sv
// ----------------------------------------------------------------------------
// Timer table
// Slot table of one-shot and recurring timers with a tick counter and id issue.
// ----------------------------------------------------------------------------
// Set and clear scan every slot once and give a single result word. A tick
// first scans every slot for due timers, then makes one pass over the table
// per expired timer (one result word each, lowest id first); with nothing due
// it ends after an empty pass with no word. One slot is read per cycle via the
// shared compare unit. Results are strobed for one cycle and cannot stall.
// Reset empties the table, clears the tick counter and sets the next id to 1.
`timescale 1ns / 1ps

module timeout_interval_timer_table_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  titt_pkg::req_t req_i,
  output logic           res_valid_o,
  output titt_pkg::res_t res_o
);
  import titt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SET  = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_DUE  = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_OUT - 1);

  // Slot payload, only meaningful where the valid bit is set.
  logic [31:0] slot_id_q    [SLOTS];
  logic        slot_rec_q   [SLOTS];
  logic [31:0] slot_delay_q [SLOTS];
  logic [31:0] slot_start_q [SLOTS];

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] due_q, due_d;
  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d, idx_inc;
  logic [31:0]      now_q, now_d;
  logic [31:0]      next_id_q, next_id_d;
  logic [31:0]      key_q, key_d;
  logic [31:0]      delay_q, delay_d;
  logic             rec_q, rec_d;
  logic             have_a_q, have_a_d;
  logic [IDX_W-1:0] a_idx_q, a_idx_d;
  logic             have_f_q, have_f_d;
  logic [IDX_W-1:0] f_idx_q, f_idx_d;
  logic [31:0]      best_id_q, best_id_d;
  logic             best_rec_q, best_rec_d;
  logic [CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic             wr_all, wr_start;
  logic [IDX_W-1:0] wr_idx;

  logic             rd_valid, rd_rec;
  logic [31:0]      rd_id, rd_delay, rd_start;
  logic [31:0]      cmp_a, cmp_b, cmp_c;
  cmp_flags_t       flags;

  logic             hit, free_now, cand, fin_ok, fin_rec, last_fire;
  logic [IDX_W-1:0] fin_idx;
  logic [31:0]      fin_id;

  assign rd_valid = valid_q[idx_q];
  assign rd_id    = slot_id_q[idx_q];
  assign rd_rec   = slot_rec_q[idx_q];
  assign rd_delay = slot_delay_q[idx_q];
  assign rd_start = slot_start_q[idx_q];

  // The due scan compares elapsed time; every other scan compares ids.
  always_comb begin
    cmp_a = rd_id;
    cmp_b = '0;
    cmp_c = key_q;
    if (state_q == ST_DUE) begin
      cmp_a = now_q;
      cmp_b = rd_start;
      cmp_c = rd_delay;
    end else if (state_q == ST_SRCH) begin
      cmp_c = best_id_q;
    end
  end

  titt_cmp u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .c_i     (cmp_c),
    .flags_o (flags)
  );

  assign idx_inc = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    due_d       = due_q;
    now_d       = now_q;
    next_id_d   = next_id_q;
    key_d       = key_q;
    delay_d     = delay_q;
    rec_d       = rec_q;
    have_a_d    = have_a_q;
    a_idx_d     = a_idx_q;
    have_f_d    = have_f_q;
    f_idx_d     = f_idx_q;
    best_id_d   = best_id_q;
    best_rec_d  = best_rec_q;
    fire_cnt_d  = fire_cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_all      = 1'b0;
    wr_start    = 1'b0;
    wr_idx      = idx_q;
    hit         = 1'b0;
    free_now    = 1'b0;
    cand        = 1'b0;
    fin_ok      = 1'b0;
    fin_rec     = 1'b0;
    fin_idx     = idx_q;
    fin_id      = rd_id;
    last_fire   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d      = '0;
          have_a_d   = 1'b0;
          have_f_d   = 1'b0;
          fire_cnt_d = '0;
          unique case (req_i.req_type) inside
            REQ_TICK: begin
              now_d   = now_q + 32'd1;
              due_d   = '0;
              state_d = ST_DUE;
            end
            REQ_SET_ONCE, REQ_SET_REC: begin
              key_d     = next_id_q;
              next_id_d = next_id_q + 32'd1;
              delay_d   = req_i.delay_ticks;
              rec_d     = (req_i.req_type == REQ_SET_REC);
              state_d   = ST_SET;
            end
            REQ_CLEAR: begin
              key_d   = req_i.timer_id;
              state_d = ST_CLR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_SET: begin
        // A slot already holding the new id wins over the lowest free slot.
        hit      = rd_valid && flags.eq;
        free_now = !rd_valid;
        if (hit && !have_a_q) begin
          have_a_d = 1'b1;
          a_idx_d  = idx_q;
        end
        if (free_now && !have_f_q) begin
          have_f_d = 1'b1;
          f_idx_d  = idx_q;
        end
        idx_d = idx_inc;
        if (idx_q == LAST_IDX) begin
          if (have_a_q || hit) begin
            fin_ok  = 1'b1;
            fin_idx = have_a_q ? a_idx_q : idx_q;
          end else if (have_f_q || free_now) begin
            fin_ok  = 1'b1;
            fin_idx = have_f_q ? f_idx_q : idx_q;
          end
          if (fin_ok) begin
            wr_all           = 1'b1;
            wr_idx           = fin_idx;
            valid_d[fin_idx] = 1'b1;
          end
          res_valid_d         = 1'b1;
          res_d.kind          = fin_ok ? KIND_SET_OK : KIND_SET_FULL;
          res_d.result_id     = key_q;
          res_d.was_recurring = 1'b0;
          res_d.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      ST_CLR: begin
        if (rd_valid && flags.eq) begin
          valid_d[idx_q] = 1'b0;
        end
        idx_d = idx_inc;
        if (idx_q == LAST_IDX) begin
          res_valid_d         = 1'b1;
          res_d.kind          = KIND_CLEARED;
          res_d.result_id     = key_q;
          res_d.was_recurring = 1'b0;
          res_d.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      ST_DUE: begin
        due_d[idx_q] = rd_valid && !flags.lt;
        idx_d        = idx_inc;
        if (idx_q == LAST_IDX) begin
          have_a_d = 1'b0;
          state_d  = ST_SRCH;
        end
      end

      ST_SRCH: begin
        // Each pass over the table finds the lowest due id and fires it.
        cand = due_q[idx_q] && (!have_a_q || flags.lt);
        if (cand) begin
          have_a_d   = 1'b1;
          a_idx_d    = idx_q;
          best_id_d  = rd_id;
          best_rec_d = rd_rec;
        end
        idx_d = idx_inc;
        if (idx_q == LAST_IDX) begin
          fin_ok  = have_a_q || cand;
          fin_idx = cand ? idx_q : a_idx_q;
          fin_id  = cand ? rd_id : best_id_q;
          fin_rec = cand ? rd_rec : best_rec_q;
          if (fin_ok) begin
            due_d[fin_idx] = 1'b0;
            last_fire      = (due_d == '0) || (fire_cnt_q == LAST_CNT);
            if (fin_rec) begin
              wr_start = 1'b1;
              wr_idx   = fin_idx;
            end else begin
              valid_d[fin_idx] = 1'b0;
            end
            res_valid_d         = 1'b1;
            res_d.kind          = KIND_EXPIRED;
            res_d.result_id     = fin_id;
            res_d.was_recurring = fin_rec;
            res_d.last          = last_fire;
            fire_cnt_d          = fire_cnt_q + 1'b1;
            have_a_d            = 1'b0;
            if (last_fire) begin
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      due_q       <= '0;
      now_q       <= '0;
      next_id_q   <= 32'd1;
      have_a_q    <= 1'b0;
      have_f_q    <= 1'b0;
      fire_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      due_q       <= due_d;
      now_q       <= now_d;
      next_id_q   <= next_id_d;
      have_a_q    <= have_a_d;
      have_f_q    <= have_f_d;
      fire_cnt_q  <= fire_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    delay_q    <= delay_d;
    rec_q      <= rec_d;
    a_idx_q    <= a_idx_d;
    f_idx_q    <= f_idx_d;
    best_id_q  <= best_id_d;
    best_rec_q <= best_rec_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_all) begin
      slot_id_q[wr_idx]    <= key_q;
      slot_rec_q[wr_idx]   <= rec_q;
      slot_delay_q[wr_idx] <= delay_q;
      slot_start_q[wr_idx] <= now_q;
    end else if (wr_start) begin
      slot_start_q[wr_idx] <= now_q;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### src/titt_checker.sv
// ----------------------------------------------------------------------------
// Timer table checker
// Port-level checks of sequencing and result words, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timeout_interval_timer_table_top_defines.svh"

module titt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input titt_pkg::res_t res_o
);
  import titt_pkg::*;

  // Every accepted request makes the block busy in the next cycle.
  `TITT_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accepted word did not start work")
  // A result word is only shown right after the block was busy.
  `TITT_ASSERT(a_res_after_work, clk_i, rst_ni, res_valid_o |-> $past(busy), "result word without work")
  // The final word of a request is shown as the block returns to idle.
  `TITT_ASSERT(a_last_idle, clk_i, rst_ni, (res_valid_o && res_o.last) |-> !busy, "block busy after final word")
  // Set and clear results are single words; only expiries carry the recurring flag.
  `TITT_ASSERT(a_single_word, clk_i, rst_ni, (res_valid_o && res_o.kind != KIND_EXPIRED) |-> (res_o.last && !res_o.was_recurring), "bad set or clear word")
  // Reset leaves the block idle with no result strobe.
  `TITT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> (!busy && !res_valid_o), "not idle in reset")

endmodule

bind timeout_interval_timer_table_top titt_checker u_titt_checker (.*);
